### src/catmull_rom_loop_evaluator_assert.svh
// Assertion macros shared by the Catmull-Rom loop evaluator RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef CATMULL_ROM_LOOP_EVALUATOR_ASSERT_SVH
`define CATMULL_ROM_LOOP_EVALUATOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define CRE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define CRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/cre_pkg.sv
// Shared types and constants of the Catmull-Rom loop evaluator.
// No dependencies; imported by every module of the block except cre_ram.
package cre_pkg;

	localparam int SLOT_W     = 6;
	localparam int COORD_W    = 32;
	localparam int ELAPSED_W  = 32;
	localparam int PC_W       = 7;
	localparam int LT_W       = 24;
	localparam int CFG_W      = 24;
	localparam int PT_W       = 3 * COORD_W;
	localparam int PAY_W      = SLOT_W + PT_W;
	localparam int ACC_W      = 40;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;
	localparam int ARITH_STAGES = 7;
	localparam int SEG_W      = 6;
	localparam int FRAC_OUT_W = 16;
	localparam logic [PC_W-1:0] PC_RESET = 7'd4;
	localparam logic [LT_W-1:0] LT_RESET = 24'd1000;

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_POINT_COUNT = 1'b0,
		REG_LOOP_TIME   = 1'b1
	} reg_idx_t;

	// Queue entry: evaluate flag plus a payload that holds either
	// {slot, x, y, z} for a load or the scaled time in its low bits.
	typedef struct packed {
		logic             eval;
		logic [PAY_W-1:0] pay;
	} item_t;

	typedef struct packed {
		logic                  valid;
		logic [SEG_W-1:0]      segment;
		logic [FRAC_OUT_W-1:0] fraction;
	} meta_t;

endpackage

### src/cre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/cre_front.sv
// Front end: accepts items, classifies them, scales the time and queues them.
// Depends on cre_pkg and the assertion macro header.
`include "catmull_rom_loop_evaluator_assert.svh"

module cre_front
	import cre_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [SLOT_W-1:0]             point_slot,
	input  logic signed [COORD_W-1:0]     coord_x,
	input  logic signed [COORD_W-1:0]     coord_y,
	input  logic signed [COORD_W-1:0]     coord_z,
	input  logic [ELAPSED_W-1:0]          elapsed_ms,
	input  logic [$clog2(MAX_POINTS+1)-1:0] cnt,
	output item_t                         head,
	output logic                          head_valid,
	input  logic                          pop
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int NUM_W = ELAPSED_W + CNT_W;

	logic [NUM_W-1:0] num;
	item_t            item;
	logic             push;
	logic             pop_do;
	item_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_q;
	logic [Q_AW-1:0]  rd_q;
	logic [Q_AW:0]    fill_q;

	assign num       = NUM_W'(elapsed_ms) * NUM_W'(cnt);
	assign item.eval = (cmd == CMD_EVAL);
	assign item.pay  = item.eval ? PAY_W'(num) : {point_slot, coord_x, coord_y, coord_z};

	assign in_ready   = (fill_q != (Q_AW+1)'(Q_DEPTH));
	assign push       = in_valid & in_ready;
	assign head_valid = (fill_q != '0);
	assign pop_do     = pop & head_valid;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_do) begin
				rd_q <= rd_q + 1'b1;
			end
			fill_q <= fill_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop_do);
		end
	end

	`CRE_ASSERT_ALWAYS(a_fill_bounded, fill_q <= (Q_AW+1)'(Q_DEPTH), "queue overfilled")
	`CRE_ASSERT_NEXT(a_fill_grows, push && !pop_do, fill_q == $past(fill_q) + 1'b1, "fill lost")

endmodule

### src/cre_axis.sv
// One coordinate axis of the Catmull-Rom basis: position and tangent by Horner.
// Depends on cre_pkg.
module cre_axis
	import cre_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] p0,
	input  logic signed [COORD_W-1:0] p1,
	input  logic signed [COORD_W-1:0] p2,
	input  logic signed [COORD_W-1:0] p3,
	input  logic [FRAC_BITS-1:0]      f,
	output logic signed [COORD_W-1:0] pos,
	output logic signed [COORD_W-1:0] tan
);

	localparam int PW = ACC_W + FRAC_BITS + 1;
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(2147483647);
	localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);

	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		s = (p + RND_HALF) >>> FRAC_BITS;
		return s[ACC_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W:0] s;
		s = ((ACC_W+1)'(v) + (ACC_W+1)'(1)) >>> 1;
		if (s > SAT_HI) begin
			s = SAT_HI;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
		end
		return s[COORD_W-1:0];
	endfunction

	logic signed [ACC_W-1:0] e0, e1, e2, e3, d12, c0, c0x3, c1, c2;

	logic signed [ACC_W-1:0] c0_s1, c0x3_s1, c1_s1, c2_s1, p1x2_s1;
	logic [FRAC_BITS-1:0]    f_s1, f_s2, f_s3, f_s4, f_s5;
	logic signed [PW-1:0]    ph_s2, pg_s2, ph_s4, pg_s4, ph_s6;
	logic signed [ACC_W-1:0] c1_s2, c2_s2, p1x2_s2;
	logic signed [ACC_W-1:0] h_s3, g_s3, c2_s3, p1x2_s3;
	logic signed [ACC_W-1:0] c2_s4, p1x2_s4;
	logic signed [ACC_W-1:0] h_s5, p1x2_s5, p1x2_s6;
	logic signed [COORD_W-1:0] tan_s5, tan_s6;

	assign e0   = ACC_W'(p0);
	assign e1   = ACC_W'(p1);
	assign e2   = ACC_W'(p2);
	assign e3   = ACC_W'(p3);
	assign d12  = e1 - e2;
	assign c0   = (e3 - e0) + (d12 <<< 1) + d12;
	assign c0x3 = c0 + (c0 <<< 1);
	assign c1   = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign c2   = e2 - e0;

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s1   <= c0;
			c0x3_s1 <= c0x3;
			c1_s1   <= c1;
			c2_s1   <= c2;
			p1x2_s1 <= e1 <<< 1;
			f_s1    <= f;

			ph_s2   <= PW'(c0_s1) * PW'(signed'({1'b0, f_s1}));
			pg_s2   <= PW'(c0x3_s1) * PW'(signed'({1'b0, f_s1}));
			c1_s2   <= c1_s1;
			c2_s2   <= c2_s1;
			p1x2_s2 <= p1x2_s1;
			f_s2    <= f_s1;

			h_s3    <= rnd(ph_s2) + c1_s2;
			g_s3    <= rnd(pg_s2) + (c1_s2 <<< 1);
			c2_s3   <= c2_s2;
			p1x2_s3 <= p1x2_s2;
			f_s3    <= f_s2;

			ph_s4   <= PW'(h_s3) * PW'(signed'({1'b0, f_s3}));
			pg_s4   <= PW'(g_s3) * PW'(signed'({1'b0, f_s3}));
			c2_s4   <= c2_s3;
			p1x2_s4 <= p1x2_s3;
			f_s4    <= f_s3;

			h_s5    <= rnd(ph_s4) + c2_s4;
			tan_s5  <= half_sat(rnd(pg_s4) + c2_s4);
			p1x2_s5 <= p1x2_s4;
			f_s5    <= f_s4;

			ph_s6   <= PW'(h_s5) * PW'(signed'({1'b0, f_s5}));
			tan_s6  <= tan_s5;
			p1x2_s6 <= p1x2_s5;

			pos     <= half_sat(rnd(ph_s6) + p1x2_s6);
			tan     <= tan_s6;
		end
	end

endmodule

### src/cre_back.sv
// Back end: pipelined divider, neighbor addressing, point tables and basis math.
// Depends on cre_pkg, cre_ram, cre_axis and the assertion macro header.
`include "catmull_rom_loop_evaluator_assert.svh"

module cre_back
	import cre_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  item_t                           head,
	input  logic                            head_valid,
	output logic                            pop,
	input  logic [$clog2(MAX_POINTS+1)-1:0] cnt,
	input  logic [LT_W-1:0]                 lt,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [COORD_W-1:0]       pos_x,
	output logic signed [COORD_W-1:0]       pos_y,
	output logic signed [COORD_W-1:0]       pos_z,
	output logic signed [COORD_W-1:0]       tan_x,
	output logic signed [COORD_W-1:0]       tan_y,
	output logic signed [COORD_W-1:0]       tan_z,
	output logic [SEG_W-1:0]                segment,
	output logic [FRAC_OUT_W-1:0]           fraction
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int NUM_W = ELAPSED_W + CNT_W;
	localparam int DIV_N = NUM_W + FRAC_BITS;
	localparam int LAST  = DIV_N - 1;

	logic adv;

	logic                 dv_valid_s [DIV_N];
	logic                 dv_ev_s    [DIV_N];
	logic [PAY_W-1:0]     dv_pay_s   [DIV_N];
	logic [LT_W-1:0]      dv_rem_s   [DIV_N];
	logic [CNT_W-1:0]     dv_mod_s   [DIV_N];
	logic [FRAC_BITS-1:0] dv_frac_s  [DIV_N];

	assign adv = !out_valid || out_ready;
	assign pop = adv;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic                 in_v;
		logic                 in_ev;
		logic [PAY_W-1:0]     in_pay;
		logic [LT_W-1:0]      in_rem;
		logic [CNT_W-1:0]     in_mod;
		logic [FRAC_BITS-1:0] in_frac;
		logic                 bit_in;
		logic [LT_W:0]        trial;
		logic [LT_W:0]        diff;
		logic                 ge;
		logic [LT_W-1:0]      nx_rem;
		logic [CNT_W-1:0]     nx_mod;
		logic [FRAC_BITS-1:0] nx_frac;

		if (k == 0) begin : g_first
			assign in_v    = head_valid;
			assign in_ev   = head.eval;
			assign in_pay  = head.pay;
			assign in_rem  = '0;
			assign in_mod  = '0;
			assign in_frac = '0;
		end else begin : g_next
			assign in_v    = dv_valid_s[k-1];
			assign in_ev   = dv_ev_s[k-1];
			assign in_pay  = dv_pay_s[k-1];
			assign in_rem  = dv_rem_s[k-1];
			assign in_mod  = dv_mod_s[k-1];
			assign in_frac = dv_frac_s[k-1];
		end

		assign trial  = {in_rem, bit_in};
		assign diff   = trial - {1'b0, lt};
		assign ge     = (trial >= {1'b0, lt});
		assign nx_rem = ge ? diff[LT_W-1:0] : trial[LT_W-1:0];

		if (k < NUM_W) begin : g_int
			// Integer quotient bits fold straight into the segment modulo.
			logic [CNT_W:0] msum;
			logic [CNT_W:0] mdiff;
			logic           mge;
			assign bit_in  = in_pay[NUM_W-1-k];
			assign msum    = {in_mod, ge};
			assign mdiff   = msum - {1'b0, cnt};
			assign mge     = (msum >= {1'b0, cnt});
			assign nx_mod  = mge ? mdiff[CNT_W-1:0] : msum[CNT_W-1:0];
			assign nx_frac = in_frac;
		end else begin : g_frac
			assign bit_in  = 1'b0;
			assign nx_mod  = in_mod;
			assign nx_frac = {in_frac[FRAC_BITS-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[k] <= 1'b0;
			end else if (adv) begin
				dv_valid_s[k] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ev_s[k]   <= in_ev;
				dv_pay_s[k]  <= in_pay;
				dv_rem_s[k]  <= nx_rem;
				dv_mod_s[k]  <= nx_mod;
				dv_frac_s[k] <= nx_frac;
			end
		end
	end

	// Neighbor addresses, all modulo the point count.
	logic [CNT_W-1:0]  seg;
	logic [CNT_W-1:0]  a0_c;
	logic [CNT_W-1:0]  a2_c;
	logic [CNT_W-1:0]  a3_c;
	logic [AW-1:0]     raddr [4];
	logic [SLOT_W-1:0] slot;
	logic              slot_ok;
	logic              we;
	logic [PT_W-1:0]   rdata [4];

	assign seg = dv_mod_s[LAST];

	always_comb begin
		logic [CNT_W:0] t2;
		logic [CNT_W:0] t3;
		t2 = {1'b0, seg} + (CNT_W+1)'(1);
		t3 = {1'b0, seg} + (CNT_W+1)'(2);
		a0_c = (seg == '0) ? (cnt - 1'b1) : (seg - 1'b1);
		if (t2 >= {1'b0, cnt}) begin
			t2 = t2 - {1'b0, cnt};
		end
		if (t3 >= {1'b0, cnt}) begin
			t3 = t3 - {1'b0, cnt};
		end
		if (t3 >= {1'b0, cnt}) begin
			t3 = t3 - {1'b0, cnt};
		end
		a2_c = t2[CNT_W-1:0];
		a3_c = t3[CNT_W-1:0];
	end

	assign raddr[0] = a0_c[AW-1:0];
	assign raddr[1] = seg[AW-1:0];
	assign raddr[2] = a2_c[AW-1:0];
	assign raddr[3] = a3_c[AW-1:0];

	assign slot    = dv_pay_s[LAST][PAY_W-1 -: SLOT_W];
	assign slot_ok = (32'(slot) < 32'(MAX_POINTS));
	assign we      = adv && dv_valid_s[LAST] && !dv_ev_s[LAST] && slot_ok;

	// One table copy per neighbor so all four reads happen in the same cycle.
	for (genvar j = 0; j < 4; j++) begin : g_tab
		cre_ram #(
			.WIDTH (PT_W),
			.DEPTH (MAX_POINTS)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (AW'(slot)),
			.wdata (dv_pay_s[LAST][PT_W-1:0]),
			.re    (adv),
			.raddr (raddr[j]),
			.rdata (rdata[j])
		);
	end

	logic [FRAC_BITS-1:0] frac_r;
	meta_t                meta_s [ARITH_STAGES+1];
	logic signed [COORD_W-1:0] pos_w [3];
	logic signed [COORD_W-1:0] tan_w [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_r <= dv_frac_s[LAST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ARITH_STAGES; i++) begin
				meta_s[i] <= '0;
			end
		end else if (adv) begin
			meta_s[0].valid    <= dv_valid_s[LAST] && dv_ev_s[LAST];
			meta_s[0].segment  <= SEG_W'(seg);
			meta_s[0].fraction <= FRAC_OUT_W'(dv_frac_s[LAST]);
			for (int i = 1; i <= ARITH_STAGES; i++) begin
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		cre_axis #(
			.FRAC_BITS (FRAC_BITS)
		) u_axis (
			.clk (clk),
			.en  (adv),
			.p0  (signed'(rdata[0][(2-a)*COORD_W +: COORD_W])),
			.p1  (signed'(rdata[1][(2-a)*COORD_W +: COORD_W])),
			.p2  (signed'(rdata[2][(2-a)*COORD_W +: COORD_W])),
			.p3  (signed'(rdata[3][(2-a)*COORD_W +: COORD_W])),
			.f   (frac_r),
			.pos (pos_w[a]),
			.tan (tan_w[a])
		);
	end

	assign out_valid = meta_s[ARITH_STAGES].valid;
	assign segment   = meta_s[ARITH_STAGES].segment;
	assign fraction  = meta_s[ARITH_STAGES].fraction;
	assign pos_x     = pos_w[0];
	assign pos_y     = pos_w[1];
	assign pos_z     = pos_w[2];
	assign tan_x     = tan_w[0];
	assign tan_y     = tan_w[1];
	assign tan_z     = tan_w[2];

	`CRE_ASSERT_ALWAYS(a_seg_below_count, !(dv_valid_s[LAST] && dv_ev_s[LAST]) || (seg < cnt), "segment not below point count")
	`CRE_ASSERT_NEXT(a_stall_freezes, !adv, $stable(frac_r), "pipeline moved during stall")

endmodule

### src/catmull_rom_loop_evaluator.sv
// Top level of the closed-loop Catmull-Rom evaluator: configuration registers,
// front end with its queue, and the back end. Depends on cre_pkg, cre_front, cre_back.
//
//   Channel   Handshake               Moves
//   -------   ---------------------   ------------------------------------------
//   config    cfg_wen                 one register write per cycle, no wait
//   input     in_valid / in_ready     load (point into table) or evaluate item
//   output    out_valid / out_ready   position, tangent, segment and fraction
//
// The block takes one item per cycle while the queue is not full. An evaluate
// transfer passes through the pipelined restoring divider, one quotient bit per
// stage, then the table read and seven stages of basis arithmetic.
// A stalled output freezes the back end; the four-entry queue keeps accepting
// items until it is full. Reset clears the configuration to four points and
// 1000 ms and empties the pipeline; the point table holds no defined contents.
module catmull_rom_loop_evaluator
	import cre_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [0:0]                cfg_idx,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [SLOT_W-1:0]         point_slot,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [ELAPSED_W-1:0]      elapsed_ms,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] pos_x,
	output logic signed [COORD_W-1:0] pos_y,
	output logic signed [COORD_W-1:0] pos_z,
	output logic signed [COORD_W-1:0] tan_x,
	output logic signed [COORD_W-1:0] tan_y,
	output logic signed [COORD_W-1:0] tan_z,
	output logic [SEG_W-1:0]          segment,
	output logic [FRAC_OUT_W-1:0]     fraction
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [PC_W-1:0]  pc_q;
	logic [LT_W-1:0]  lt_q;
	logic [CNT_W-1:0] cnt_eff;
	logic [LT_W-1:0]  lt_eff;
	item_t            head;
	logic             head_valid;
	logic             pop;

	// Configuration writes land directly; the port has no wait and no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_RESET;
			lt_q <= LT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_POINT_COUNT: pc_q <= cfg_wdata[PC_W-1:0];
				REG_LOOP_TIME:   lt_q <= cfg_wdata[LT_W-1:0];
				default:         lt_q <= lt_q;
			endcase
		end
	end

	// A count of zero acts as one point, and counts beyond the table are
	// clamped to its size. A zero loop time acts as one millisecond.
	always_comb begin
		if (pc_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (32'(pc_q) > 32'(MAX_POINTS)) begin
			cnt_eff = CNT_W'(MAX_POINTS);
		end else begin
			cnt_eff = CNT_W'(pc_q);
		end
	end

	assign lt_eff = (lt_q == '0) ? LT_W'(1) : lt_q;

	// The front end scales the time by the point count and queues the item.
	cre_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.point_slot (point_slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.elapsed_ms (elapsed_ms),
		.cnt        (cnt_eff),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// Loads travel the same pipeline as evaluations, so a table write always
	// happens in order with respect to the reads of earlier evaluations.
	cre_back #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cnt        (cnt_eff),
		.lt         (lt_eff),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tan_x      (tan_x),
		.tan_y      (tan_y),
		.tan_z      (tan_z),
		.segment    (segment),
		.fraction   (fraction)
	);

endmodule

### verif/tb_top.sv
// Self-checking testbench for the closed-loop Catmull-Rom evaluator.
// Depends on cre_pkg and catmull_rom_loop_evaluator; predicts each evaluation in place.
module tb_top
	import cre_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 64;
	localparam int FRAC_SHIFT  = 16;
	// Cycles to let the pipeline drain after the last expected result, since a
	// load in flight produces nothing we could wait for.
	localparam int DRAIN_CYCLES = 90;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] tang [3];
		logic [5:0]         seg;
		logic [15:0]        frac;
	} curve_sample_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [0:0]                cfg_idx;
	logic [CFG_W-1:0]          cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	logic                      cmd;
	logic [SLOT_W-1:0]         point_slot;
	logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
	logic [ELAPSED_W-1:0]      elapsed_ms;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	logic signed [COORD_W-1:0] tan_x, tan_y, tan_z;
	logic [SEG_W-1:0]          segment;
	logic [FRAC_OUT_W-1:0]     fraction;

	catmull_rom_loop_evaluator u_top (.*);

	// Shadow copy of the control point table and the two registers.
	logic signed [31:0] ctrl_pts [3][TABLE_DEPTH];
	int unsigned        loop_points;
	int unsigned        loop_period;
	curve_sample_t      pending_samples [$];
	bit                 broken;
	bit                 sender_calm;
	bit                 sink_calm;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Most gaps are short, a few are long; a calm stretch has none at all.
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Round-to-nearest product in Q16 and the final halving with saturation.
	function automatic longint rnd_mul(longint a, longint f);
		return (a * f + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
	endfunction

	function automatic logic signed [31:0] halve_sat(longint v2);
		longint v;
		v = (v2 + 1) >>> 1;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// Evaluates one axis of the spline from the four neighbouring points.
	task automatic spline_axis(input int ax, input int unsigned nb [4], input longint f,
			output logic signed [31:0] p, output logic signed [31:0] d);
		longint p0, p1, p2, p3, c0, c1, c2, h, g;
		p0 = ctrl_pts[ax][nb[0]];
		p1 = ctrl_pts[ax][nb[1]];
		p2 = ctrl_pts[ax][nb[2]];
		p3 = ctrl_pts[ax][nb[3]];
		c0 = -p0 + 3 * p1 - 3 * p2 + p3;
		c1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c2 = p2 - p0;
		h = rnd_mul(c0, f) + c1;
		h = rnd_mul(h, f) + c2;
		h = rnd_mul(h, f) + 2 * p1;
		g = rnd_mul(3 * c0, f) + 2 * c1;
		g = rnd_mul(g, f) + c2;
		p = halve_sat(h);
		d = halve_sat(g);
	endtask

	task automatic predict_sample(input logic [31:0] el);
		curve_sample_t s;
		longint unsigned cnt, per, num, q, r, sg;
		longint f;
		int unsigned nb [4];
		cnt = 64'((loop_points == 0) ? 1 :
			(loop_points > TABLE_DEPTH ? TABLE_DEPTH : loop_points));
		per = 64'((loop_period == 0) ? 1 : loop_period);
		num = longint'(el) * cnt;
		q = num / per;
		r = num % per;
		sg = q % cnt;
		f = longint'((r << FRAC_SHIFT) / per);
		nb[0] = 32'((sg + cnt - 1) % cnt);
		nb[1] = 32'(sg);
		nb[2] = 32'((sg + 1) % cnt);
		nb[3] = 32'((sg + 2) % cnt);
		for (int a = 0; a < 3; a++)
			spline_axis(a, nb, f, s.pos[a], s.tang[a]);
		s.seg = sg[5:0];
		s.frac = f[15:0];
		pending_samples.insert(pending_samples.size(), s);
	endtask

	// Sends one item and updates the shadow state once the transfer happens.
	task automatic send_item(input cmd_t c, input logic [5:0] slot,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [31:0] el);
		int gap;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		point_slot <= slot;
		coord_x    <= x;
		coord_y    <= y;
		coord_z    <= z;
		elapsed_ms <= el;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_LOAD) begin
			ctrl_pts[0][slot] = x;
			ctrl_pts[1][slot] = y;
			ctrl_pts[2][slot] = z;
		end else begin
			predict_sample(el);
		end
	endtask

	task automatic send_load(input logic [5:0] slot, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		send_item(CMD_LOAD, slot, x, y, z, $urandom);
	endtask

	task automatic send_eval(input logic [31:0] el);
		send_item(CMD_EVAL, 6'($urandom), $urandom, $urandom, $urandom, el);
	endtask

	// Waits for every expected sample, then lets trailing loads retire.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_POINT_COUNT) loop_points = val & 32'h7F;
		else loop_period = val & 32'hFF_FFFF;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		unique case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_elapsed();
		unique case ($urandom_range(0, 4))
			0: return $urandom_range(0, 5000);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 100);
			default: return $urandom;
		endcase
	endfunction

	// The table is filled completely first, so no evaluation ever touches an
	// entry that was never written.
	task automatic test_fill_table();
		for (int s = 0; s < TABLE_DEPTH; s++)
			send_load(6'(s), rand_coord(), rand_coord(), rand_coord());
	endtask

	// Extreme coordinates that drive the basis into saturation, and times at
	// zero, at the top of the field and on a segment boundary.
	task automatic test_extremes();
		for (int s = 0; s < 4; s++)
			send_load(6'(s), s[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
				s[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, s[1] ? 32'h0 : 32'hFFFF_FFFF);
		send_eval(32'd0);
		send_eval(32'hFFFF_FFFF);
		send_eval(32'd250);
		send_eval(32'd249);
		send_eval(32'd999);
		send_eval(32'd125);
		send_load(6'd0, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
		send_eval(32'd1);
		wait_idle();
	endtask

	// Each register setting is a phase of its own: a burst of mostly
	// evaluations, with fresh loads mixed in so the table keeps changing.
	task automatic run_phase(input int unsigned cnt, input int unsigned per, input int n);
		write_reg(REG_POINT_COUNT, cnt);
		write_reg(REG_LOOP_TIME, per);
		sender_calm = ($urandom_range(0, 3) == 0);
		sink_calm   = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_load(6'($urandom), rand_coord(), rand_coord(), rand_coord());
			else
				send_eval(rand_elapsed());
		end
		sender_calm = 1'b0;
		sink_calm   = 1'b0;
		wait_idle();
	endtask

	// Out-of-range count, zero period and both register extremes.
	task automatic test_config_corners();
		run_phase(0, 0, 15);
		run_phase(127, 16777215, 15);
		run_phase(1, 1, 15);
		run_phase(64, 16777215, 15);
		run_phase(65, 1000, 15);
	endtask

	task automatic test_random();
		for (int p = 0; p < 15; p++)
			run_phase($urandom_range(0, 127),
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 24'hFF_FFFF),
				120);
	endtask

	// Result sink: random backpressure with occasional calm stretches.
	int sink_hold;
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= sink_calm || ($urandom_range(0, 2) != 0);
			sink_hold <= pick_gap(sink_calm);
		end
	end

	task automatic check_word(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			broken = 1'b1;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	// Every result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		curve_sample_t s;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				broken = 1'b1;
				$display("%0t: result transfer with no evaluation outstanding", $time);
			end else begin
				s = pending_samples.pop_front();
				check_word("pos_x", s.pos[0], pos_x);
				check_word("pos_y", s.pos[1], pos_y);
				check_word("pos_z", s.pos[2], pos_z);
				check_word("tan_x", s.tang[0], tan_x);
				check_word("tan_y", s.tang[1], tan_y);
				check_word("tan_z", s.tang[2], tan_z);
				check_word("segment", {26'd0, s.seg}, {26'd0, segment});
				check_word("fraction", {16'd0, s.frac}, {16'd0, fraction});
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_idx     = REG_POINT_COUNT;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		cmd         = CMD_LOAD;
		point_slot  = '0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		elapsed_ms  = '0;
		out_ready   = 1'b0;
		sink_hold   = 0;
		broken      = 1'b0;
		sender_calm = 1'b0;
		sink_calm   = 1'b0;
		loop_points = 32'(PC_RESET);
		loop_period = 32'(LT_RESET);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_extremes();
		test_config_corners();
		test_random();
		wait_idle();

		if (!broken)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
